// ===== hdl/swr_pkg.sv =====
package swr_pkg;

    localparam int POINTS_DEF    = 50;
    localparam int FRAC_BITS_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 6;
    localparam int FREQ_W   = 32;
    localparam int SPAN_W   = 19;
    localparam int CFG_W    = 32;
    localparam int CFG_A_W  = 1;
    localparam int WINDOW   = 5;
    localparam int SUM_W    = SAMPLE_W + 3;

    localparam logic [FREQ_W-1:0] CENTER_FREQ_RST = 32'd14000000;
    localparam logic [SPAN_W-1:0] SPAN_HZ_RST     = 19'd100000;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_CENTER_FREQ = 1'd0;
    localparam logic [CFG_A_W-1:0] REG_SPAN_HZ     = 1'd1;

    // func codes
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] vswr_sample;
    } in_item_t;

    typedef struct packed {
        logic                smooth_valid;
        logic [INDEX_W-1:0]  smooth_index;
        logic [SAMPLE_W-1:0] smooth_value;
        logic [FREQ_W-1:0]   tune_freq;
    } out_item_t;

endpackage

// ===== hdl/swr_sweep_smoother.sv =====
// SWR sweep smoother. Takes one beat per clock when not stalled and returns
// one result beat per input beat (one window/index stage, one divide stage). A
// restart beat (func = 1) refills the window with 1.0, resets the point index,
// latches sweep start = center_freq - span_hz/2 and answers with that start
// frequency; a sample beat answers with the truncated five-point average for
// the point two steps back and the tune frequency of the next point. The last
// four samples are held in a tap line; with the point index they give every
// window, ends clamped. Register writes take effect at the next restart.
module swr_sweep_smoother #(
    parameter int POINTS    = swr_pkg::POINTS_DEF,
    parameter int FRAC_BITS = swr_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swr_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [swr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  swr_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output swr_pkg::out_item_t            out_data
);

    import swr_pkg::*;

    localparam int IDX_W  = $clog2(POINTS);
    localparam int PROD_W = SPAN_W + IDX_W;

    localparam logic [SAMPLE_W-1:0] ONE_Q      = SAMPLE_W'(1 << FRAC_BITS);
    localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(POINTS - 1);
    localparam logic [IDX_W-1:0]    IDX_BACK   = IDX_W'(POINTS - 2);
    localparam logic [SPAN_W-1:0]   WIDTH_RST  = SPAN_HZ_RST & ~SPAN_W'(1);
    localparam logic [FREQ_W-1:0]   LO_RST     =
        CENTER_FREQ_RST - FREQ_W'(SPAN_HZ_RST >> 1);

    logic [FREQ_W-1:0]   center_freq_reg;
    logic [SPAN_W-1:0]   span_hz_reg;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SPAN_W-1:0]   width_reg;
    logic [FREQ_W-1:0]   lo_reg, lo_next;
    logic [SAMPLE_W-1:0] tap_reg [1:4];

    logic                s1_valid_reg;
    logic                s1_restart_reg;
    logic [IDX_W-1:0]    s1_center_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [FREQ_W-1:0]   s1_lo_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg, out_data_next;

    logic                adv;
    logic                accept;
    logic                restart;
    logic [SUM_W-1:0]    s0, t1, t2, t3, t4;
    logic [SUM_W-1:0]    sum;
    logic [IDX_W-1:0]    center;
    logic [SUM_W-1:0]    avg;
    logic [PROD_W-1:0]   offset;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;
    assign restart  = (in_data.func == FUNC_RESTART);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_freq_reg <= CENTER_FREQ_RST;
            span_hz_reg     <= SPAN_HZ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CENTER_FREQ: center_freq_reg <= cfg_wdata;
                REG_SPAN_HZ:     span_hz_reg     <= cfg_wdata[SPAN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign s0 = SUM_W'(in_data.vswr_sample);
    assign t1 = SUM_W'(tap_reg[1]);
    assign t2 = SUM_W'(tap_reg[2]);
    assign t3 = SUM_W'(tap_reg[3]);
    assign t4 = SUM_W'(tap_reg[4]);

    // window is idx-4..idx, clamped at both ends of the ring
    always_comb
    begin
        if (idx_reg == IDX_W'(0))
            sum = t4 + t3 + t2 + t1 + t1;
        else if (idx_reg == IDX_W'(1))
            sum = t4 + t3 + t2 + t2 + t2;
        else if (idx_reg == IDX_W'(2))
            sum = s0 + t1 + t2 + t2 + t2;
        else if (idx_reg == IDX_W'(3))
            sum = s0 + t1 + t2 + t3 + t3;
        else
            sum = s0 + t1 + t2 + t3 + t4;
    end

    always_comb
    begin
        if (idx_reg < IDX_W'(2))
            center = idx_reg + IDX_BACK;
        else
            center = idx_reg - IDX_W'(2);
    end

    always_comb
    begin
        lo_next = center_freq_reg - FREQ_W'(span_hz_reg >> 1);
        if (restart || idx_reg == IDX_LAST)
        begin
            idx_next  = '0;
            prod_next = '0;
        end
        else
        begin
            idx_next  = idx_reg + IDX_W'(1);
            prod_next = prod_reg + PROD_W'(width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            prod_reg  <= '0;
            width_reg <= WIDTH_RST;
            lo_reg    <= LO_RST;
            for (int i = 1; i <= 4; i++)
                tap_reg[i] <= ONE_Q;
        end
        else if (accept)
        begin
            idx_reg  <= idx_next;
            prod_reg <= prod_next;
            if (restart)
            begin
                width_reg <= span_hz_reg & ~SPAN_W'(1);
                lo_reg    <= lo_next;
                for (int i = 1; i <= 4; i++)
                    tap_reg[i] <= ONE_Q;
            end
            else
            begin
                tap_reg[1] <= in_data.vswr_sample;
                tap_reg[2] <= tap_reg[1];
                tap_reg[3] <= tap_reg[2];
                tap_reg[4] <= tap_reg[3];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_restart_reg <= restart;
            s1_center_reg  <= center;
            s1_sum_reg     <= sum;
            s1_prod_reg    <= prod_next;
            s1_lo_reg      <= restart ? lo_next : lo_reg;
        end
    end

    swr_divc #(
        .WIDTH   (SUM_W),
        .DIVISOR (WINDOW)
    ) u_div_avg (
        .dividend (s1_sum_reg),
        .quotient (avg)
    );

    swr_divc #(
        .WIDTH   (PROD_W),
        .DIVISOR (POINTS)
    ) u_div_freq (
        .dividend (s1_prod_reg),
        .quotient (offset)
    );

    always_comb
    begin
        out_data_next.tune_freq = s1_lo_reg + FREQ_W'(offset);
        if (s1_restart_reg)
        begin
            out_data_next.smooth_valid = 1'b0;
            out_data_next.smooth_index = '0;
            out_data_next.smooth_value = '0;
        end
        else
        begin
            out_data_next.smooth_valid = 1'b1;
            out_data_next.smooth_index = INDEX_W'(s1_center_reg);
            out_data_next.smooth_value = avg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/swr_divc.sv =====
module swr_divc #(
    parameter int WIDTH   = 19,
    parameter int DIVISOR = 5
) (
    input  logic [WIDTH-1:0] dividend,
    output logic [WIDTH-1:0] quotient
);

    // floor(x / DIVISOR) as x * ceil(2^SH / DIVISOR) >> SH, exact for all WIDTH-bit x
    localparam int SH    = WIDTH + $clog2(DIVISOR);
    localparam int PW    = SH + WIDTH;
    localparam int MW    = WIDTH + 2;
    localparam longint unsigned MUL_L = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] MUL = MUL_L[MW-1:0];

    logic [PW-1:0] prod;

    assign prod     = PW'(dividend) * PW'(MUL);
    assign quotient = prod[SH +: WIDTH];

endmodule

// ===== sim/swr_sweep_smoother_tb.sv =====
module swr_sweep_smoother_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import swr_pkg::*;

    localparam int SWEEP_POINTS = POINTS_DEF;
    localparam logic [SAMPLE_W-1:0] SWR_ONE = SAMPLE_W'(1 << FRAC_BITS_DEF);
    localparam int TOTAL_BEATS = 1225;
    localparam int CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = REG_CENTER_FREQ;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;

    // predictor state
    logic [SAMPLE_W-1:0] vswr_ring [0:SWEEP_POINTS-1];
    int unsigned sweep_pos;
    logic [FREQ_W-1:0] center_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [FREQ_W-1:0] sweep_lo;
    logic [FREQ_W-1:0] sweep_hi;

    out_item_t expected_points [$];
    out_item_t want;
    int mismatches = 0;
    int beats_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    swr_sweep_smoother uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void restart_sweep_model();
        logic [FREQ_W-1:0] half;
        int i;
        half = FREQ_W'(span_reg >> 1);
        for (i = 0; i < SWEEP_POINTS; i++)
            vswr_ring[i] = SWR_ONE;
        sweep_pos = 0;
        sweep_lo = center_reg - half;
        sweep_hi = center_reg + half;
    endfunction

    function automatic logic [FREQ_W-1:0] tune_at(input int unsigned pos);
        logic [FREQ_W-1:0] width;
        logic [63:0] prod;
        logic [63:0] offset;
        width = sweep_hi - sweep_lo;
        prod = {32'd0, width} * 64'(pos);
        offset = prod / 64'(SWEEP_POINTS);
        return sweep_lo + offset[FREQ_W-1:0];
    endfunction

    function automatic out_item_t predict_point(input in_item_t beat);
        out_item_t res;
        int unsigned slot;
        int unsigned mid;
        int k;
        int n;
        logic [SUM_W-1:0] total;
        res = '0;
        if (beat.func == FUNC_RESTART)
        begin
            restart_sweep_model();
            res.tune_freq = tune_at(0);
            return res;
        end
        slot = sweep_pos;
        vswr_ring[slot] = beat.vswr_sample;
        mid = (SWEEP_POINTS + slot - 2) % SWEEP_POINTS;
        total = '0;
        for (n = -2; n <= 2; n++)
        begin
            k = int'(mid) + n;
            if (k < 0)
                k = 0;
            else if (k > SWEEP_POINTS - 1)
                k = SWEEP_POINTS - 1;
            total += vswr_ring[k];
        end
        sweep_pos = (slot + 1 >= SWEEP_POINTS) ? 0 : slot + 1;
        res.smooth_valid = 1'b1;
        res.smooth_index = mid[INDEX_W-1:0];
        res.smooth_value = SAMPLE_W'(total / WINDOW);
        res.tune_freq = tune_at(sweep_pos);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_swr();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return SAMPLE_W'($urandom_range(256, 1024));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_center();
        case ($urandom_range(0, 5))
            0: return 32'd250000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom_range(1000000, 30000000));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_span();
        case ($urandom_range(0, 5))
            0: return 32'd50000;
            1: return 32'd500000;
            2: return 32'($urandom);
            default: return 32'($urandom_range(50000, 500000));
        endcase
    endfunction

    // entered just after a posedge; returns at the accepting posedge
    task automatic send_beat(input logic f, input logic [SAMPLE_W-1:0] s);
        in_item_t beat;
        int gap;
        beat.func = f;
        beat.vswr_sample = s;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do
            @(posedge clk);
        while (in_stall);
        expected_points.push_back(predict_point(beat));
        beats_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_CENTER_FREQ)
            center_reg = val;
        else
            span_reg = val[SPAN_W-1:0];
    endtask

    // reset bounds, low-end clamp, restart ignores its sample field
    task automatic test_reset_bounds();
        send_beat(FUNC_SAMPLE, 16'h0000);
        repeat (4) send_beat(FUNC_SAMPLE, 16'hFFFF);
        send_beat(FUNC_SAMPLE, 16'h0100);
        send_beat(FUNC_SAMPLE, 16'h5555);
        send_beat(FUNC_SAMPLE, 16'hAAAA);
        send_beat(FUNC_RESTART, 16'hFFFF);
        send_beat(FUNC_SAMPLE, 16'hFFFF);
        send_beat(FUNC_SAMPLE, 16'h0001);
    endtask

    // writes only land on restart; frequency wrap; span masking
    task automatic test_register_extremes();
        drain_results();
        write_reg(REG_CENTER_FREQ, 32'd250000);
        write_reg(REG_SPAN_HZ, 32'd50000);
        send_beat(FUNC_SAMPLE, 16'h1234);
        send_beat(FUNC_SAMPLE, 16'hFEDC);
        send_beat(FUNC_RESTART, 16'h0000);
        send_beat(FUNC_SAMPLE, 16'h0200);
        send_beat(FUNC_SAMPLE, 16'h0300);
        drain_results();
        write_reg(REG_CENTER_FREQ, 32'hFFFF_FFFF);
        write_reg(REG_SPAN_HZ, 32'hFFFF_FFFF);
        send_beat(FUNC_RESTART, 16'h8000);
        send_beat(FUNC_SAMPLE, 16'hFFFF);
        send_beat(FUNC_SAMPLE, 16'h0000);
        drain_results();
        write_reg(REG_CENTER_FREQ, 32'd0);
        write_reg(REG_SPAN_HZ, 32'd500000);
        send_beat(FUNC_RESTART, 16'h0000);
        send_beat(FUNC_SAMPLE, 16'h7FFF);
        send_beat(FUNC_SAMPLE, 16'h8001);
    endtask

    // full and partial sweeps under random settings, with stray restarts
    task automatic test_random_sweeps();
        int phase;
        int run_len;
        int i;
        phase = 0;
        while (beats_sent < TOTAL_BEATS)
        begin
            drain_results();
            idle_on = (phase % 4) != 3;
            if (phase % 3 != 2)
                write_reg(REG_CENTER_FREQ, pick_center());
            if (phase % 2 == 0)
                write_reg(REG_SPAN_HZ, pick_span());
            send_beat(FUNC_RESTART, SAMPLE_W'($urandom));
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                  : $urandom_range(50, 160);
            for (i = 0; i < run_len; i++)
            begin
                if (phase == 2 && i == run_len / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 3)
                    send_beat(FUNC_RESTART, rand_swr());
                else
                    send_beat(FUNC_SAMPLE, rand_swr());
            end
            phase++;
        end
        idle_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 99) < 20)
        begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result beat, got %p", $time, out_data);
                mismatches++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_data.smooth_valid !== want.smooth_valid)
                begin
                    $display("%0t: smooth_valid expected %0d, got %0d",
                             $time, want.smooth_valid, out_data.smooth_valid);
                    mismatches++;
                end
                if (out_data.smooth_index !== want.smooth_index)
                begin
                    $display("%0t: smooth_index expected %0d, got %0d",
                             $time, want.smooth_index, out_data.smooth_index);
                    mismatches++;
                end
                if (out_data.smooth_value !== want.smooth_value)
                begin
                    $display("%0t: smooth_value expected %0d, got %0d",
                             $time, want.smooth_value, out_data.smooth_value);
                    mismatches++;
                end
                if (out_data.tune_freq !== want.tune_freq)
                begin
                    $display("%0t: tune_freq expected %0d, got %0d",
                             $time, want.tune_freq, out_data.tune_freq);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        center_reg = CENTER_FREQ_RST;
        span_reg = SPAN_HZ_RST;
        restart_sweep_model();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_bounds();
        test_register_extremes();
        test_random_sweeps();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== swr_sweep_smoother.f =====
hdl/swr_pkg.sv
hdl/swr_divc.sv
hdl/swr_sweep_smoother.sv
sim/swr_sweep_smoother_tb.sv
